@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/gtb_pkg.sv @@
// ----------------------------------------------------------------------------
// gtb_pkg
// Formats, constants and the tanh table of the GELU backward pipeline.
// ----------------------------------------------------------------------------
package gtb_pkg;

  // Element format: signed Q4.12.
  localparam int DataW    = 16;
  localparam int FracBits = 12;

  // Stream payload widths.
  localparam int InTdataW  = 2 * DataW;
  localparam int OutTdataW = DataW;

  // Magnitude of |x| below the large-activation threshold (4.0).
  localparam int XaW = 14;
  // Magnitude of a two's complement value, including the most negative one.
  localparam int MagW = DataW + 1;

  // Q24 constants: 0.044715, 3*0.044715, sqrt(2/pi).
  localparam logic [19:0] CCube  = 20'd750193;
  localparam logic [21:0] CCube3 = 22'd2250580;
  localparam logic [23:0] CScale = 24'd13386282;

  // Tanh table: Q15 samples at |u| = 4*i/TanhDepth, i = 0 .. TanhDepth.
  localparam int TanhDepth = 256;
  localparam int TanhIdxW  = $clog2(TanhDepth);
  localparam int TanhAddrW = $clog2(TanhDepth + 1);
  localparam int UW        = 27;
  localparam int TFracW    = UW - 1 - TanhIdxW;
  localparam int TW        = 16;

  typedef logic [TanhDepth:0][TW-1:0] tanh_tab_t;

  // Side information that travels with every element.
  typedef struct packed {
    logic            xneg;
    logic            xbig;
    logic            gneg;
    logic [MagW-1:0] ga;
    logic            last;
  } side_t;

  // Unsigned 64-bit quotient by restoring shift and subtract.
  function automatic logic [63:0] div_u64(input logic [63:0] num,
                                          input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds the table at elaboration: E = exp(-2|u|) in Q30 from a Taylor
  // series of exp(-|u|/8) squared four times, then tanh = (1-E)/(1+E).
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t          tab;
    logic [63:0]        z;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        q;
    logic signed [63:0] acc;
    logic [63:0]        one;
    one = 64'd1 << 30;
    for (int i = 0; i <= TanhDepth; i++) begin
      // The step 1/(2*TanhDepth) is a power of two.
      z    = (64'(i) << 30) >> (TanhIdxW + 1);
      term = one;
      acc  = $signed(one);
      for (int n = 1; n <= 20; n++) begin
        term = div_u64((term * z) >> 30, 64'(n));
        if ((n & 1) == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = '0;
      end
      e = 64'(acc);
      if (e > one) begin
        e = one;
      end
      for (int n = 0; n < 4; n++) begin
        e = (e * e + (one >> 1)) >> 30;
      end
      q = div_u64(((one - e) << 15) + ((one + e) >> 1), one + e);
      tab[i] = q[TW-1:0];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TanhTab = build_tanh_tab();

endpackage

@@ rtl/gtb_tanh.sv @@
// ----------------------------------------------------------------------------
// gtb_tanh
// Two-stage |tanh| of a Q24 magnitude: table read, then linear interpolation.
// ----------------------------------------------------------------------------
module gtb_tanh (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [gtb_pkg::UW-1:0] u_i,   // |u| in Q24
  output logic [gtb_pkg::TW-1:0] t_o    // |tanh(u)| in Q15
);
  import gtb_pkg::*;

  logic                     big_q;
  logic [TW-1:0]            t0_q;
  logic [TW-1:0]            diff_q;
  logic [TFracW-1:0]        f_q;
  logic [TW-1:0]            t_q;

  logic [TanhAddrW-1:0]     addr0;
  logic [TanhAddrW-1:0]     addr1;
  logic [TW-1:0]            t0_d;
  logic [TW-1:0]            t1_d;
  logic [TW+TFracW:0]       prod;
  logic [TW-1:0]            t_d;

  // Table read of both interval ends; the table grows monotonically.
  always_comb begin
    addr0 = {1'b0, u_i[UW-2 -: TanhIdxW]};
    addr1 = addr0 + TanhAddrW'(1);
    t0_d  = TanhTab[addr0];
    t1_d  = TanhTab[addr1];
  end

  // Interpolation between the two samples, rounded to nearest.
  always_comb begin
    prod = (TW+TFracW+1)'(diff_q) * (TW+TFracW+1)'(f_q)
         + ((TW+TFracW+1)'(1) << (TFracW - 1));
    t_d  = big_q ? TW'(1 << 15) : t0_q + prod[TFracW +: TW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      big_q  <= u_i[UW-1];
      t0_q   <= t0_d;
      diff_q <= t1_d - t0_d;
      f_q    <= u_i[TFracW-1:0];
      t_q    <= t_d;
    end
  end

  assign t_o = t_q;

endmodule

@@ rtl/gelu_tanh_backward.sv @@
// ----------------------------------------------------------------------------
// gelu_tanh_backward
// Input gradient of tanh-approximated GELU, one Q4.12 element per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block takes one element per clock cycle unless stalled and returns
// its gradient. All twelve register stages advance together and stall as a
// whole only while the output register holds a result that has not been
// taken; s_axis_tready is high whenever the output register is empty or is
// being read in the same cycle. The latency is set by the chain of dependent
// multiplications (x^2, x^3, the tanh argument, the table interpolation,
// tanh^2, the sech^2 product and the final gradient product), each followed
// by a register. tlast is carried unchanged alongside its element.
module gelu_tanh_backward (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] act_value, [31:16] grad_out
  input  logic [gtb_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] grad_in
  output logic [gtb_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);
  import gtb_pkg::*;

  localparam int NumStages = 12;

  logic                 en;
  logic [NumStages:1]   valid_q;
  side_t                side_q [1:NumStages-1];
  side_t                side_d;

  // Stage payload registers.
  logic [XaW-1:0]       xa1_q, xa2_q, xa3_q;
  logic [27:0]          a2_q;
  logic [29:0]          a3_q;
  logic [26:0]          poly_q;
  logic [26:0]          s_q;
  logic [28:0]          m0_q;
  logic [UW-1:0]        u_q;
  logic [28:0]          m1_q5, m1_q6, m1_q7, m1_q8;
  logic [TW-1:0]        t_w;
  logic [TW-1:0]        t8_q, t9_q;
  logic [30:0]          sech_q;
  logic [29:0]          m_q;
  logic                 dneg_q;
  logic [31:0]          dmag_q;
  logic                 sgn_q;
  logic [48:0]          mag_q;
  logic [DataW-1:0]     res_q;
  logic                 last_q;

  // Stage input.
  logic [DataW-1:0]     x_in, g_in;
  logic [MagW-1:0]      xa_in, ga_in;

  // Next values.
  logic [41:0]          x3_d;
  logic [49:0]          pc_d;
  logic [29:0]          a3_d;
  logic [26:0]          poly_d;
  logic [49:0]          c_d;
  logic [26:0]          s_d;
  logic [40:0]          m0p_d;
  logic [28:0]          m0_d;
  logic [50:0]          up_d;
  logic [52:0]          m1p_d;
  logic [59:0]          mp_d;
  logic [30:0]          t1_d;
  logic [34:0]          t2_d;
  logic [36:0]          dsum_d;
  logic [35:0]          dabs_d;
  logic                 dneg_d;
  logic [31:0]          dmag_d;
  logic [48:0]          rsum_d;
  logic [18:0]          r_d;
  logic                 rneg_d;
  logic [DataW-1:0]     res_d;

  // The whole pipeline moves unless a result waits at the output.
  assign en            = !valid_q[NumStages] || m_axis_tready;
  assign s_axis_tready = en;

  // Element valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-1:1], s_axis_tvalid};
    end
  end

  // Input split: magnitudes and signs of x and g.
  always_comb begin
    x_in   = s_axis_tdata[DataW-1:0];
    g_in   = s_axis_tdata[2*DataW-1:DataW];
    xa_in  = x_in[DataW-1] ? (MagW'(1) << DataW) - {1'b0, x_in} : {1'b0, x_in};
    ga_in  = g_in[DataW-1] ? (MagW'(1) << DataW) - {1'b0, g_in} : {1'b0, g_in};
    side_d = '{xneg:  x_in[DataW-1],
               xbig:  |xa_in[MagW-1:XaW],
               gneg:  g_in[DataW-1],
               ga:    ga_in,
               last:  s_axis_tlast};
  end

  // Side information shift line.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= side_d;
      for (int k = 2; k < NumStages; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Polynomial stages: x^3 and 1 + 3c*x^2, then the tanh argument parts.
  always_comb begin
    x3_d   = 42'(a2_q) * 42'(xa2_q) + 42'(1 << (FracBits - 1));
    a3_d   = x3_d[FracBits +: 30];
    pc_d   = 50'(CCube3) * 50'(a2_q) + 50'(1 << 23);
    poly_d = 27'(1 << 24) + 27'(pc_d[49:24]);
    c_d    = 50'(CCube) * 50'(a3_q) + 50'(1 << 23);
    s_d    = 27'({xa3_q, 12'b0}) + 27'(c_d[49:24]);
    m0p_d  = 41'(xa3_q) * 41'(poly_q) + 41'(1 << (FracBits - 1));
    m0_d   = m0p_d[FracBits +: 29];
    up_d   = 51'(CScale) * 51'(s_q) + 51'(1 << 23);
    m1p_d  = 53'(CScale) * 53'(m0_q) + 53'(1 << 23);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa1_q  <= xa_in[XaW-1:0];
      xa2_q  <= xa1_q;
      a2_q   <= 28'(xa1_q) * 28'(xa1_q);
      xa3_q  <= xa2_q;
      a3_q   <= a3_d;
      poly_q <= poly_d;
      s_q    <= s_d;
      m0_q   <= m0_d;
      u_q    <= up_d[24 +: UW];
      m1_q5  <= m1p_d[24 +: 29];
      m1_q6  <= m1_q5;
      m1_q7  <= m1_q6;
    end
  end

  // Tanh of the argument, two stages.
  gtb_tanh u_tanh (
    .clk_i (clk_i),
    .en_i  (en),
    .u_i   (u_q),
    .t_o   (t_w)
  );

  // sech^2 = 1 - tanh^2, then the derivative of the argument times sech^2.
  always_comb begin
    mp_d = 60'(m1_q8) * 60'(sech_q) + 60'(1 << 29);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t8_q   <= t_w;
      sech_q <= 31'(1 << 30) - 31'(32'(t_w) * 32'(t_w));
      m1_q8  <= m1_q7;
      t9_q   <= t8_q;
      m_q    <= mp_d[30 +: 30];
    end
  end

  // Derivative d in Q30, with the large-activation case and clamp to +-2.
  always_comb begin
    t2_d = {5'(m_q >> 25), m_q[24:0], 5'b0};
    if (side_q[9].xneg) begin
      t1_d   = 31'((32'd32768 - 32'(t9_q)) << 14);
      dsum_d = 37'(t1_d) - 37'(t2_d);
    end else begin
      t1_d   = 31'((32'd32768 + 32'(t9_q)) << 14);
      dsum_d = 37'(t1_d) + 37'(t2_d);
    end
    dneg_d = dsum_d[36];
    dabs_d = dneg_d ? 36'(-dsum_d) : dsum_d[35:0];
    if (side_q[9].xbig) begin
      dneg_d = 1'b0;
      dabs_d = side_q[9].xneg ? '0 : 36'(1 << 30);
    end
    dmag_d = (dabs_d > 36'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : dabs_d[31:0];
  end

  // Gradient product, then rounding half away from zero and saturation.
  always_comb begin
    rsum_d = mag_q + 49'(1 << 29);
    r_d    = rsum_d[30 +: 19];
    rneg_d = sgn_q && (r_d != '0);
    if (rneg_d) begin
      res_d = (r_d > 19'd32768) ? 16'h8000 : 16'(17'h1_0000 - 17'(r_d));
    end else begin
      res_d = (r_d > 19'd32767) ? 16'h7fff : r_d[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dneg_q <= dneg_d;
      dmag_q <= dmag_d;
      sgn_q  <= dneg_q ^ side_q[10].gneg;
      mag_q  <= 49'(dmag_q) * 49'(side_q[10].ga);
      res_q  <= res_d;
      last_q <= side_q[11].last;
    end
  end

  assign m_axis_tvalid = valid_q[NumStages];
  assign m_axis_tdata  = res_q;
  assign m_axis_tlast  = last_q;

endmodule

@@ rtl/gtb_checker.sv @@
// ----------------------------------------------------------------------------
// gtb_checker
// Port-level checks of the GELU backward stream block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gtb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [gtb_pkg::InTdataW-1:0]  s_axis_tdata,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [gtb_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // A stalled result stays offered with the same payload.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // A stalled result freezes the pipeline, so no new transfer is taken.
  `ASSERT_SAME(a_stall_blocks_in, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

  // With the output register empty the block always takes a transfer.
  `ASSERT_SAME(a_empty_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // A taken result frees the pipeline in the same cycle.
  `ASSERT_SAME(a_take_ready, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, s_axis_tready)

endmodule

bind gelu_tanh_backward gtb_checker u_gtb_checker (.*);

@@ tb/gelu_grad_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gelu_grad_monitor
// Watches both stream channels of the GELU backward block. Every element
// taken in is run through an independent fixed-point model of the tanh-GELU
// derivative times the upstream gradient. Each result that leaves the block
// is compared against the oldest pending expectation.
// ----------------------------------------------------------------------------
module gelu_grad_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  // [15:0] act_value, [31:16] grad_out
  input  logic [gtb_pkg::InTdataW-1:0]  s_tdata_i,
  input  logic                          s_tlast_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  // [15:0] grad_in
  input  logic [gtb_pkg::OutTdataW-1:0] m_tdata_i,
  input  logic                          m_tlast_i,
  output int                            fail_count_o,
  output int                            pending_count_o
);

  // Fixed-point constants of the derivative, Q24 unless noted.
  localparam logic [63:0] OneQ24   = 64'd1 << 24;
  localparam logic [63:0] HalfQ24  = 64'd1 << 23;
  localparam logic [63:0] FourQ24  = 64'd4 << 24;
  localparam logic [63:0] OneQ30   = 64'd1 << 30;
  localparam logic [63:0] HalfQ30  = 64'd1 << 29;
  localparam logic [63:0] KCube    = 64'd750193;
  localparam logic [63:0] KCube3   = 64'd2250580;
  localparam logic [63:0] KScale   = 64'd13386282;
  localparam longint      DLimit   = 64'sd2147483648;
  localparam int          LutDepth = 256;

  typedef struct packed {
    logic [15:0] grad_in;
    logic        last;
  } grad_t;

  logic [15:0] tanh_lut [0:LutDepth];
  grad_t       grad_in_q [$];

  // Tanh samples in Q15 at |u| = 4*i/depth: exp(-2|u|) from a series of
  // exp(-|u|/8), squared four times, then (1-E)/(1+E).
  initial begin : build_lut
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] q;
    longint      acc;
    int          i;
    int          n;
    for (i = 0; i <= LutDepth; i++) begin
      z    = (64'(i) << 30) / 64'(2 * LutDepth);
      term = OneQ30;
      acc  = longint'(OneQ30);
      for (n = 1; n <= 20; n++) begin
        term = ((term * z) >> 30) / 64'(n);
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      e = 64'(acc);
      if (e > OneQ30) begin
        e = OneQ30;
      end
      for (n = 0; n < 4; n++) begin
        e = (e * e + HalfQ30) >> 30;
      end
      q = (((OneQ30 - e) << 15) + ((OneQ30 + e) >> 1)) / (OneQ30 + e);
      tanh_lut[i] = q[15:0];
    end
  end

  function automatic logic [63:0] q24_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + HalfQ24) >> 24;
  endfunction

  // |u| in Q24 to |tanh(u)| in Q15, interpolated between table samples.
  function automatic logic [63:0] tanh_q15(input logic [63:0] u);
    logic [63:0] p;
    logic [63:0] idx;
    logic [63:0] f;
    if (u >= FourQ24) begin
      return 64'd32768;
    end
    p   = u * 64'(LutDepth);
    idx = p >> 26;
    f   = p & ((64'd1 << 26) - 64'd1);
    if (idx >= 64'(LutDepth)) begin
      return 64'd32768;
    end
    return (64'(tanh_lut[idx]) * ((64'd1 << 26) - f) +
            64'(tanh_lut[idx + 1]) * f + (64'd1 << 25)) >> 26;
  endfunction

  // Input gradient g * d(x), rounded half away from zero and saturated.
  function automatic grad_t predict_grad(input logic [15:0] x, input logic [15:0] g,
                                         input logic last);
    logic        xneg;
    logic        gneg;
    logic        dneg;
    logic        rneg;
    logic [63:0] xa;
    logic [63:0] ga;
    logic [63:0] a24;
    logic [63:0] a2;
    logic [63:0] a3;
    logic [63:0] u;
    logic [63:0] t;
    logic [63:0] sech;
    logic [63:0] poly;
    logic [63:0] m;
    logic [63:0] dmag;
    logic [63:0] r;
    longint      d;
    longint      t1;
    longint      t2;
    grad_t       res;
    xneg = x[15];
    gneg = g[15];
    xa   = xneg ? (64'd65536 - {48'd0, x}) : {48'd0, x};
    ga   = gneg ? (64'd65536 - {48'd0, g}) : {48'd0, g};
    a24  = xa << 12;

    // Beyond |x| = 4 the derivative is exactly the step value.
    if (a24 >= FourQ24) begin
      d = xneg ? 0 : longint'(OneQ30);
    end else begin
      a2   = q24_mul(a24, a24);
      a3   = q24_mul(a2, a24);
      u    = q24_mul(KScale, a24 + q24_mul(KCube, a3));
      t    = tanh_q15(u);
      sech = OneQ30 - t * t;
      poly = OneQ24 + q24_mul(KCube3, a2);
      m    = q24_mul(q24_mul(a24, poly), KScale);
      m    = (m * sech + HalfQ30) >> 30;
      t2   = longint'(m << 5);
      if (xneg) begin
        t1 = longint'((64'd32768 - t) << 14);
        d  = t1 - t2;
      end else begin
        t1 = longint'((64'd32768 + t) << 14);
        d  = t1 + t2;
      end
    end

    if (d > DLimit) begin
      d = DLimit;
    end
    if (d < -DLimit) begin
      d = -DLimit;
    end
    dneg = d < 0;
    dmag = dneg ? 64'(-d) : 64'(d);

    r    = (dmag * ga + HalfQ30) >> 30;
    rneg = (dneg != gneg) && (r != 0);
    if (rneg) begin
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      r = 64'd65536 - r;
    end else if (r > 64'd32767) begin
      r = 64'd32767;
    end
    res.grad_in = r[15:0];
    res.last    = last;
    return res;
  endfunction

  // Queue an expectation per input transfer, check each output transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    grad_t exp_grad;
    int    errs;
    if (!rst_ni) begin
      grad_in_q.delete();
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      errs = 0;
      if (s_tvalid_i && s_tready_i) begin
        grad_in_q.push_back(predict_grad(s_tdata_i[15:0], s_tdata_i[31:16], s_tlast_i));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (grad_in_q.size() == 0) begin
          $error("grad_in: unexpected result %0d with nothing pending",
                 $signed(m_tdata_i));
          errs++;
        end else begin
          exp_grad = grad_in_q.pop_front();
          if (m_tdata_i !== exp_grad.grad_in) begin
            $error("grad_in: expected %0d, actual %0d",
                   $signed(exp_grad.grad_in), $signed(m_tdata_i));
            errs++;
          end
          if (m_tlast_i !== exp_grad.last) begin
            $error("last_flag: expected %0d, actual %0d", exp_grad.last, m_tlast_i);
            errs++;
          end
        end
      end
      fail_count_o    <= fail_count_o + errs;
      pending_count_o <= grad_in_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the GELU backward block. A directed set covers the
// field extremes, the large-activation and tanh saturation regions and result
// overflow; random elements follow under four idle and stall patterns, with a
// long output hold-off and a full drain in between. Checking is done by the
// channel monitor instantiated beside the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IdleLimit    = 2000;
  localparam int TailCycles   = 24;
  localparam int ItemsPerPhase = 100;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [gtb_pkg::InTdataW-1:0]  s_axis_tdata;
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [gtb_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                          m_axis_tlast;

  int fail_count;
  int pending_count;
  int src_idle_pct;
  int sink_stall_pct;
  int sink_hold;
  int idle_cycles;

  gelu_tanh_backward uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  gelu_grad_monitor u_grad_mon (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tlast_i       (s_axis_tlast),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tlast_i       (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Output side: random stalls, or a counted hold-off when one is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // End the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offers one element after a random gap and returns at the falling edge
  // that follows its transfer.
  task automatic send_elem(input logic [15:0] act, input logic [15:0] grad,
                           input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {grad, act};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_count != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Activations: mostly inside the interpolated region, some near the
  // saturation threshold, some tiny, the rest over the full range.
  function automatic logic [15:0] rand_act();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(32766)) - 16383;
      6:                v = int'($urandom_range(1024)) - 512;
      7: begin
        v = int'($urandom_range(16384, 11000));
        if ($urandom_range(1) == 1) begin
          v = -v;
        end
      end
      default:          v = int'($urandom_range(65535));
    endcase
    return 16'(v);
  endfunction

  function automatic logic [15:0] rand_grad();
    logic [15:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'h0000;
          3:       v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
      end
      1:       v = 16'(int'($urandom_range(512)) - 256);
      default: v = 16'($urandom_range(65535));
    endcase
    return v;
  endfunction

  initial begin
    int phase;
    int k;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_hold      = 0;
    idle_cycles    = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed elements: zero, extremes, the 4.0 threshold on both sides,
    // the region where tanh saturates, and results that overflow.
    send_elem(16'h0000, 16'h1000, 1'b0);
    send_elem(16'h7FFF, 16'h1000, 1'b0);
    send_elem(16'h8000, 16'h1000, 1'b0);
    send_elem(16'd16383, 16'h1000, 1'b0);
    send_elem(16'd16384, 16'h1000, 1'b0);
    send_elem(16'hC000, 16'h1000, 1'b0);
    send_elem(16'hC001, 16'h1000, 1'b0);
    send_elem(16'd14336, 16'h1000, 1'b0);
    send_elem(16'hC800, 16'h1000, 1'b0);
    send_elem(16'h0001, 16'h7FFF, 1'b0);
    send_elem(16'hFFFF, 16'h8000, 1'b0);
    send_elem(16'd6144, 16'h7FFF, 1'b0);
    send_elem(16'd6144, 16'h8000, 1'b0);
    send_elem(16'hE800, 16'h7FFF, 1'b0);
    send_elem(16'd4096, 16'hFFFF, 1'b0);
    send_elem(16'hF000, 16'h0001, 1'b0);
    send_elem(16'h7FFF, 16'h8000, 1'b0);
    send_elem(16'h8000, 16'h7FFF, 1'b0);
    send_elem(16'd2048, 16'h4000, 1'b0);
    send_elem(16'hF800, 16'hC000, 1'b1);
    send_elem(16'h5555, 16'hAAAA, 1'b0);
    send_elem(16'hAAAA, 16'h5555, 1'b1);
    drain_results();

    // Random elements under four idle and stall patterns.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 58;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 58;
        end
        default: begin
          src_idle_pct   = 26;
          sink_stall_pct = 26;
        end
      endcase
      for (k = 0; k < ItemsPerPhase; k++) begin
        // Long output hold-off while input keeps coming, so the pipeline
        // fills up and back-pressures the input.
        if (phase == 0 && k == 30) begin
          sink_hold = 80;
        end
        // Let every pending result come out before going on.
        if (phase == 2 && k == 50) begin
          drain_results();
        end
        send_elem(rand_act(), rand_grad(), $urandom_range(7) == 0);
      end
      drain_results();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
